### hw/rtl/fqrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_pkg: shared types and constants for the four-queue round-robin drain
// Holds operation codes, direction characters, the drain state type and the
// control structs passed between the queue chains and the core.
// ----------------------------------------------------------------------------
package fqrr_pkg;

    localparam int NUM_QUEUES      = 4;
    localparam int QID_W           = 2;
    localparam int ITEM_W          = 64;
    localparam int CHAR_W          = 8;
    localparam int OP_W            = 2;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_CODE_WIDTH  = 64;

    localparam logic [OP_W-1:0] OP_SELECT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN   = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;

    localparam logic [QID_W-1:0] QID_ONE   = 2'd0;
    localparam logic [QID_W-1:0] QID_THREE = 2'd1;
    localparam logic [QID_W-1:0] QID_TWO   = 2'd2;
    localparam logic [QID_W-1:0] QID_OTHER = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } drain_state_t;

    // Per-cell control: load the enqueued code, or take the neighbor's code.
    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctrl_t;

    // Per-queue request from the core.
    typedef struct packed {
        logic enq;
        logic deq;
    } queue_ctrl_t;

    // Per-queue status back to the core.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Map a raw direction character onto a queue index.
    function automatic logic [QID_W-1:0] map_direction(input logic [CHAR_W-1:0] ch);
        logic [QID_W-1:0] qid;
        unique case (ch)
            CHAR_ONE:   qid = QID_ONE;
            CHAR_THREE: qid = QID_THREE;
            CHAR_TWO:   qid = QID_TWO;
            default:    qid = QID_OTHER;
        endcase
        return qid;
    endfunction

endpackage

### hw/rtl/fqrr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_cell: one storage cell of a queue chain
// Holds one code; loads a new code on enqueue or takes its upper neighbor's
// code when the queue shifts toward the head.
// ----------------------------------------------------------------------------
module fqrr_cell #(
    parameter int CODE_WIDTH = fqrr_pkg::DEF_CODE_WIDTH
) (
    input  logic                   aclk,
    input  fqrr_pkg::cell_ctrl_t   ctrl,
    input  logic [CODE_WIDTH-1:0]  wr_data,
    input  logic [CODE_WIDTH-1:0]  neighbor_data,
    output logic [CODE_WIDTH-1:0]  data
);
    import fqrr_pkg::*;

    logic [CODE_WIDTH-1:0] data_reg;
    logic [CODE_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.wr) begin
            data_next = wr_data;
        end else if (ctrl.shift) begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### hw/rtl/fqrr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_queue: one FIFO queue built as a chain of cells
// Cell 0 is the head. Enqueue writes the cell at the fill count; dequeue
// shifts every cell one place toward the head.
// ----------------------------------------------------------------------------
module fqrr_queue #(
    parameter int QUEUE_DEPTH = fqrr_pkg::DEF_QUEUE_DEPTH,
    parameter int CODE_WIDTH  = fqrr_pkg::DEF_CODE_WIDTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fqrr_pkg::queue_ctrl_t   ctrl,
    input  logic [CODE_WIDTH-1:0]   enq_data,
    output logic [CODE_WIDTH-1:0]   head_data,
    output logic [CNT_W-1:0]        count,
    output fqrr_pkg::queue_stat_t   stat
);
    import fqrr_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  full;
    logic                  do_enq;
    logic                  do_deq;
    logic [CODE_WIDTH-1:0] cell_data [QUEUE_DEPTH];

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_enq = ctrl.enq && !full;
    assign do_deq = ctrl.deq && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (do_enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctrl_t            cctrl;
        logic [CODE_WIDTH-1:0] upper;

        assign cctrl.wr    = do_enq && (count_reg == CNT_W'(i));
        assign cctrl.shift = do_deq;

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign upper = '0;
        end else begin : g_mid
            assign upper = cell_data[i+1];
        end

        fqrr_cell #(
            .CODE_WIDTH(CODE_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (cctrl),
            .wr_data       (enq_data),
            .neighbor_data (upper),
            .data          (cell_data[i])
        );
    end

    assign head_data  = cell_data[0];
    assign count      = count_reg;
    assign stat.full  = full;
    assign stat.empty = (count_reg == '0);

endmodule

### hw/rtl/four_queue_round_robin_drain_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_queue_round_robin_drain_core: four queues drained in round-robin order
// Select and enqueue requests take effect when accepted. A drain request moves the
// core into a drain phase that empties the queues one entry per cycle while m_ready is high.
// ----------------------------------------------------------------------------
// Timing: select and enqueue requests complete at their acceptance edge; the
//   first result of a drain passes through the drain state and then the output
//   register before it is presented.
// Throughput: one request per cycle for select and enqueue while no drain runs;
//   a drain of N queued entries gives N results (one result without an entry if
//   all queues are empty), one head shift per cycle while m_ready stays high.
// Reset: aresetn clears counts, direction (to the "other" queue), overflow, the
//   drain state and m_valid; queue cells and the result payload are not cleared.
module four_queue_round_robin_drain_core #(
    parameter int QUEUE_DEPTH = fqrr_pkg::DEF_QUEUE_DEPTH,
    parameter int CODE_WIDTH  = fqrr_pkg::DEF_CODE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fqrr_pkg::OP_W-1:0]     s_operation,
    input  logic [fqrr_pkg::CHAR_W-1:0]   s_direction_char,
    input  logic [fqrr_pkg::ITEM_W-1:0]   s_item_code,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fqrr_pkg::ITEM_W-1:0]   m_item_code_res,
    output logic                          m_valid_res,
    output logic                          m_last,
    output logic                          m_overflow
);
    import fqrr_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);

    // Control state.
    drain_state_t     state_reg;
    drain_state_t     state_next;
    logic [QID_W-1:0] cur_q_reg;
    logic [QID_W-1:0] cur_q_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [QID_W-1:0] ptr_reg;
    logic [QID_W-1:0] ptr_next;
    logic [TOT_W-1:0] remain_reg;
    logic [TOT_W-1:0] remain_next;

    // Output register. The payload holds while a result waits for m_ready.
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [ITEM_W-1:0] m_code_reg;
    logic [ITEM_W-1:0] m_code_next;
    logic              m_vres_reg;
    logic              m_vres_next;
    logic              m_last_reg;
    logic              m_last_next;
    logic              m_ovf_reg;
    logic              m_ovf_next;

    // Request decode.
    logic s_fire;
    logic req_select;
    logic req_enqueue;
    logic req_drain;

    // Queue side.
    queue_ctrl_t           qctrl     [NUM_QUEUES];
    queue_stat_t           qstat     [NUM_QUEUES];
    logic [CNT_W-1:0]      qcount    [NUM_QUEUES];
    logic [CODE_WIDTH-1:0] qhead     [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] non_empty;
    logic [TOT_W-1:0]      total;

    // Drain step.
    logic             out_free;
    logic             emit;
    logic             emit_entry;
    logic [QID_W-1:0] sel_q;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        req_select  = 1'b0;
        req_enqueue = 1'b0;
        req_drain   = 1'b0;
        unique case (s_operation)
            OP_SELECT:  req_select  = s_fire;
            OP_ENQUEUE: req_enqueue = s_fire;
            OP_DRAIN:   req_drain   = s_fire;
            default: begin
                // The unused operation code is taken and ignored.
            end
        endcase
    end

    // Four queue chains. Enqueue goes to the selected direction; dequeue comes
    // from the queue that the round-robin search picks this cycle.
    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        assign qctrl[q].enq = req_enqueue && (cur_q_reg == QID_W'(q));
        assign qctrl[q].deq = emit_entry && (sel_q == QID_W'(q));
        assign non_empty[q] = !qstat[q].empty;

        fqrr_queue #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CODE_WIDTH  (CODE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_queue (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (qctrl[q]),
            .enq_data  (s_item_code[CODE_WIDTH-1:0]),
            .head_data (qhead[q]),
            .count     (qcount[q]),
            .stat      (qstat[q])
        );
    end

    // Total number of queued entries, sampled when a drain is accepted.
    always_comb begin
        total = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            total = total + TOT_W'(qcount[q]);
        end
    end

    // Round-robin pick: the first non-empty queue at or after the pointer.
    // Starting at queue 0 and moving past each served queue reproduces the
    // order of visiting queues 0 to 3 in repeated rounds.
    always_comb begin
        logic [QID_W-1:0] cand;
        logic             found;
        sel_q = ptr_reg;
        found = 1'b0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            cand = ptr_reg + QID_W'(k);
            if (!found && non_empty[cand]) begin
                sel_q = cand;
                found = 1'b1;
            end
        end
    end

    // Direction and sticky overflow.
    always_comb begin
        cur_q_next    = cur_q_reg;
        overflow_next = overflow_reg;
        if (req_select) begin
            cur_q_next = map_direction(s_direction_char);
        end
        if (req_enqueue && qstat[cur_q_reg].full) begin
            overflow_next = 1'b1;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Next-state logic of the drain sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_drain) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free && (remain_reg <= TOT_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic of the drain sequencer: one result per free output slot.
    // With nothing queued, a single result without an entry closes the drain.
    always_comb begin
        emit        = 1'b0;
        emit_entry  = 1'b0;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_drain) begin
                    ptr_next    = '0;
                    remain_next = total;
                end
            end
            ST_DRAIN: begin
                emit = out_free;
                if (out_free && (remain_reg != '0)) begin
                    emit_entry  = 1'b1;
                    ptr_next    = sel_q + QID_W'(1);
                    remain_next = remain_reg - TOT_W'(1);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Output register loading.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_vres_next  = m_vres_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_vres_next  = emit_entry;
            m_last_next  = (remain_reg <= TOT_W'(1));
            m_ovf_next   = overflow_reg;
            m_code_next  = emit_entry ? ITEM_W'(qhead[sel_q]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_q_reg    <= QID_OTHER;
            overflow_reg <= 1'b0;
            ptr_reg      <= '0;
            remain_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_q_reg    <= cur_q_next;
            overflow_reg <= overflow_next;
            ptr_reg      <= ptr_next;
            remain_reg   <= remain_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_vres_reg <= m_vres_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_item_code_res = m_code_reg;
    assign m_valid_res     = m_vres_reg;
    assign m_last          = m_last_reg;
    assign m_overflow      = m_ovf_reg;

endmodule

### hw/rtl/fqrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_checker: port-level checks for the four-queue round-robin drain core
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fqrr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [fqrr_pkg::OP_W-1:0]     s_operation,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [fqrr_pkg::ITEM_W-1:0]   m_item_code_res,
    input logic                          m_valid_res,
    input logic                          m_last
);
    import fqrr_pkg::*;

    // A result that carries no entry only appears as the sole, final result.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> m_last)
        else $error("result without an entry is not marked last");

    // A result that carries no entry shows a zero code.
    a_empty_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_item_code_res == '0))
        else $error("result without an entry has a nonzero code");

    // An accepted drain request drops s_ready right after it is taken.
    a_drain_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_DRAIN)) |=> !s_ready)
        else $error("request channel ready right after a drain request");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_item_code_res) && $stable(m_valid_res)
             && $stable(m_last)))
        else $error("stalled result changed");

endmodule

bind four_queue_round_robin_drain_core fqrr_checker u_fqrr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_operation     (s_operation),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_item_code_res (m_item_code_res),
    .m_valid_res     (m_valid_res),
    .m_last          (m_last)
);
